>>> rtl/ole_pkg.sv
// Shared types and codes for the ordered list engine.
package ole_pkg;

  // Request kinds
  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_REMOVE  = 3'd1;
  localparam logic [2:0] REQ_SEARCH  = 3'd2;
  localparam logic [2:0] REQ_REVERSE = 3'd3;
  localparam logic [2:0] REQ_REPLACE = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         list_pos;
    logic signed [31:0] item_value;
  } ole_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] list_length;
  } ole_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SHIFT_DN,
    ST_SCAN,
    ST_REPL,
    ST_SWAP_RD,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_DONE
  } ole_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_UP,
    OP_PUT,
    OP_DN,
    OP_SCAN,
    OP_REP,
    OP_SWAP_RD,
    OP_SWAP_A,
    OP_SWAP_B
  } ole_op_t;

  // Controller to datapath
  typedef struct packed {
    ole_op_t op;
    logic    out_load;
  } ole_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       st_nz;
    logic       multi;
    logic       up_more;
    logic       dn_more;
    logic       scan_end;
    logic       swap_more;
  } ole_stat_t;

endpackage

>>> rtl/ole_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/ole_ctrl.sv
// Controller state machine for the ordered list engine.
module ole_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  ole_pkg::ole_stat_t stat,
  output ole_pkg::ole_cmd_t  cmd
);

  ole_pkg::ole_state_t state, state_next;
  logic                out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ole_pkg::ST_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ole_pkg::ST_IDLE: begin
        if (req_valid) state_next = ole_pkg::ST_DISPATCH;
      end
      ole_pkg::ST_DISPATCH: begin
        case (stat.req_type)
          ole_pkg::REQ_INSERT:
            state_next = stat.st_nz ? ole_pkg::ST_DONE : ole_pkg::ST_SHIFT_UP;
          ole_pkg::REQ_REMOVE:
            state_next = stat.st_nz ? ole_pkg::ST_DONE : ole_pkg::ST_SHIFT_DN;
          ole_pkg::REQ_SEARCH:
            state_next = ole_pkg::ST_SCAN;
          ole_pkg::REQ_REVERSE:
            state_next = stat.multi ? ole_pkg::ST_SWAP_RD : ole_pkg::ST_DONE;
          ole_pkg::REQ_REPLACE:
            state_next = stat.st_nz ? ole_pkg::ST_DONE : ole_pkg::ST_REPL;
          default:
            state_next = ole_pkg::ST_DONE;
        endcase
      end
      ole_pkg::ST_SHIFT_UP: begin
        if (!stat.up_more) state_next = ole_pkg::ST_PUT;
      end
      ole_pkg::ST_PUT:      state_next = ole_pkg::ST_DONE;
      ole_pkg::ST_SHIFT_DN: begin
        if (!stat.dn_more) state_next = ole_pkg::ST_DONE;
      end
      ole_pkg::ST_SCAN: begin
        if (stat.scan_end) state_next = ole_pkg::ST_DONE;
      end
      ole_pkg::ST_REPL:     state_next = ole_pkg::ST_DONE;
      ole_pkg::ST_SWAP_RD:  state_next = ole_pkg::ST_SWAP_A;
      ole_pkg::ST_SWAP_A:   state_next = ole_pkg::ST_SWAP_B;
      ole_pkg::ST_SWAP_B: begin
        state_next = stat.swap_more ? ole_pkg::ST_SWAP_A : ole_pkg::ST_DONE;
      end
      ole_pkg::ST_DONE: begin
        if (out_free) state_next = ole_pkg::ST_IDLE;
      end
      default: state_next = ole_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.op       = ole_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      ole_pkg::ST_IDLE:     cmd.op = req_valid ? ole_pkg::OP_LOAD : ole_pkg::OP_NONE;
      ole_pkg::ST_DISPATCH: cmd.op = ole_pkg::OP_SETUP;
      ole_pkg::ST_SHIFT_UP: cmd.op = ole_pkg::OP_UP;
      ole_pkg::ST_PUT:      cmd.op = ole_pkg::OP_PUT;
      ole_pkg::ST_SHIFT_DN: cmd.op = ole_pkg::OP_DN;
      ole_pkg::ST_SCAN:     cmd.op = ole_pkg::OP_SCAN;
      ole_pkg::ST_REPL:     cmd.op = ole_pkg::OP_REP;
      ole_pkg::ST_SWAP_RD:  cmd.op = ole_pkg::OP_SWAP_RD;
      ole_pkg::ST_SWAP_A:   cmd.op = ole_pkg::OP_SWAP_A;
      ole_pkg::ST_SWAP_B:   cmd.op = ole_pkg::OP_SWAP_B;
      ole_pkg::ST_DONE:     cmd.out_load = out_free;
      default:              cmd.op = ole_pkg::OP_NONE;
    endcase
  end

endmodule

>>> rtl/ole_dp.sv
// Datapath for the ordered list engine: entry RAM, cursors, count, result register.
module ole_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ole_pkg::ole_req_t  req,
  input  ole_pkg::ole_cmd_t  cmd,
  output ole_pkg::ole_stat_t stat,
  output ole_pkg::ole_rsp_t  rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int LW = (CW > 4) ? CW : 4;

  // Latched request
  logic [2:0]    r_type;
  logic [3:0]    r_pos;
  logic [31:0]   r_val;

  // Working registers
  logic [CW-1:0] count;
  logic [CW-1:0] at;
  logic [CW-1:0] cur;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [31:0]   hold;
  logic          found;
  logic [AW-1:0] fidx;
  logic [1:0]    st;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;

  // Setup values
  logic [LW-1:0] pos_l;
  logic [LW-1:0] n_l;
  logic [LW-1:0] nm1_l;
  logic [CW-1:0] at_calc;
  logic [1:0]    st_calc;
  logic          scan_more;
  logic          match;

  ole_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Clamp position and pick status for the latched request
  always_comb begin
    pos_l   = LW'(r_pos);
    n_l     = LW'(count);
    nm1_l   = n_l - LW'(1);
    at_calc = '0;
    st_calc = ole_pkg::STAT_DONE;
    case (r_type)
      ole_pkg::REQ_INSERT: begin
        at_calc = CW'((pos_l < n_l) ? pos_l : n_l);
        if (count == CW'(DEPTH)) begin
          st_calc = ole_pkg::STAT_FULL;
        end else if (count == '0 && r_pos != 4'd0) begin
          st_calc = ole_pkg::STAT_EMPTY;
        end
      end
      ole_pkg::REQ_REMOVE, ole_pkg::REQ_REPLACE: begin
        at_calc = CW'((pos_l < nm1_l) ? pos_l : nm1_l);
        if (count == '0) st_calc = ole_pkg::STAT_EMPTY;
      end
      default: begin
        at_calc = '0;
        st_calc = ole_pkg::STAT_DONE;
      end
    endcase
  end

  assign scan_more = (cur < count);
  assign match     = pend && (rdata_a == r_val);

  // Status to controller
  always_comb begin
    stat.req_type  = r_type;
    stat.st_nz     = (st_calc != ole_pkg::STAT_DONE);
    stat.multi     = (count > CW'(1));
    stat.up_more   = (cur > at);
    stat.dn_more   = (cur < count);
    stat.scan_end  = match || (!scan_more && !pend);
    stat.swap_more = ({1'b0, lo} + (AW + 1)'(2)) < {1'b0, hi};
  end

  // RAM addressing per command
  always_comb begin
    we      = 1'b0;
    waddr   = pend_addr;
    wdata   = rdata_a;
    raddr_a = AW'(cur);
    raddr_b = hi;
    case (cmd.op)
      ole_pkg::OP_UP: begin
        we      = pend;
        raddr_a = AW'(cur - CW'(1));
      end
      ole_pkg::OP_DN: begin
        we = pend;
      end
      ole_pkg::OP_PUT, ole_pkg::OP_REP: begin
        we    = 1'b1;
        waddr = AW'(at);
        wdata = r_val;
      end
      ole_pkg::OP_SWAP_RD: begin
        raddr_a = lo;
        raddr_b = hi;
      end
      ole_pkg::OP_SWAP_A: begin
        we    = 1'b1;
        waddr = lo;
        wdata = rdata_b;
      end
      ole_pkg::OP_SWAP_B: begin
        we      = 1'b1;
        waddr   = hi;
        wdata   = hold;
        raddr_a = lo + AW'(1);
        raddr_b = hi - AW'(1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Control registers: count and pending-write flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (cmd.op)
        ole_pkg::OP_SETUP: pend <= 1'b0;
        ole_pkg::OP_UP:    pend <= (cur > at);
        ole_pkg::OP_PUT:   count <= count + CW'(1);
        ole_pkg::OP_DN: begin
          pend <= (cur < count);
          if (!(cur < count)) count <= count - CW'(1);
        end
        ole_pkg::OP_SCAN:  pend <= scan_more;
        default:           pend <= pend;
      endcase
    end
  end

  // Payload registers: request, cursors, search result
  always_ff @(posedge clk) begin
    case (cmd.op)
      ole_pkg::OP_LOAD: begin
        r_type <= req.req_type;
        r_pos  <= req.list_pos;
        r_val  <= req.item_value;
      end
      ole_pkg::OP_SETUP: begin
        st    <= st_calc;
        at    <= at_calc;
        lo    <= '0;
        hi    <= AW'(count - CW'(1));
        found <= 1'b0;
        fidx  <= '0;
        if (r_type == ole_pkg::REQ_INSERT) begin
          cur <= count;
        end else if (r_type == ole_pkg::REQ_REMOVE) begin
          cur <= at_calc + CW'(1);
        end else begin
          cur <= '0;
        end
      end
      ole_pkg::OP_UP: begin
        if (cur > at) begin
          pend_addr <= AW'(cur);
          cur       <= cur - CW'(1);
        end
      end
      ole_pkg::OP_DN: begin
        if (cur < count) begin
          pend_addr <= AW'(cur - CW'(1));
          cur       <= cur + CW'(1);
        end
      end
      ole_pkg::OP_SCAN: begin
        if (match) begin
          found <= 1'b1;
          fidx  <= pend_addr;
        end
        if (scan_more) begin
          pend_addr <= AW'(cur);
          cur       <= cur + CW'(1);
        end
      end
      ole_pkg::OP_SWAP_A: hold <= rdata_a;
      ole_pkg::OP_SWAP_B: begin
        lo <= lo + AW'(1);
        hi <= hi - AW'(1);
      end
      default: hold <= hold;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status      <= st;
      rsp.found       <= found;
      rsp.found_index <= 4'(fidx);
      rsp.list_length <= 5'(count);
    end
  end

endmodule

>>> rtl/ordered_list_engine_unit.sv
// Top level of the ordered list engine.
//
// Keeps an ordered list of up to DEPTH signed 32-bit values, empty after
// reset, and answers each insert, remove, search, reverse or replace request
// with one result. Requests are handled one at a time. Shifts and searches
// move one entry per cycle through the entry RAM; reverse swaps the entries
// pair by pair, writing the low entry and then the high one through the
// single write port and reading both with the two read ports. A finished
// result sits in an output register, so the next request is taken while
// the previous result waits.
module ordered_list_engine_unit #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ole_pkg::ole_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ole_pkg::ole_rsp_t rsp
);

  ole_pkg::ole_cmd_t  cmd;
  ole_pkg::ole_stat_t stat;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
